// File: hw/rtl/tesp_pkg.sv
`default_nettype none

package tesp_pkg;

	localparam int MAX_PARAMS_DEF       = 16;
	localparam int OSC_BUFFER_BYTES_DEF = 64;

	localparam int PARAM_W = 16;
	localparam int IDX_W   = 6;

	localparam logic [7:0] C_ESC      = 8'h1B;
	localparam logic [7:0] C_BEL      = 8'h07;
	localparam logic [7:0] C_ST       = 8'h9C;
	localparam logic [7:0] C_CSI      = 8'h5B;
	localparam logic [7:0] C_OSC      = 8'h5D;
	localparam logic [7:0] C_DCS      = 8'h50;
	localparam logic [7:0] C_SEMI     = 8'h3B;
	localparam logic [7:0] C_DIGIT_LO = 8'h30;
	localparam logic [7:0] C_DIGIT_HI = 8'h39;
	localparam logic [7:0] C_QMARK    = 8'h3F;
	localparam logic [7:0] C_GT       = 8'h3E;
	localparam logic [7:0] C_FINAL_LO = 8'h40;
	localparam logic [7:0] C_FINAL_HI = 8'h7E;
	localparam logic [7:0] C_INTER_LO = 8'h20;
	localparam logic [7:0] C_INTER_HI = 8'h2F;

	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_CSI    = 2'd1,
		KIND_OSC    = 2'd2,
		KIND_DCS    = 2'd3
	} tesp_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC,
		ST_CSI_ARG,
		ST_CSI_MID,
		ST_OSC,
		ST_DCS,
		ST_EMIT
	} tesp_state_t;

	typedef struct packed {
		logic [7:0] byte_in;
	} tesp_byte_t;

	typedef struct packed {
		logic [1:0]         seq_kind;
		logic [7:0]         final_code;
		logic [7:0]         private_mark;
		logic [4:0]         param_count;
		logic [IDX_W-1:0]   item_index;
		logic [PARAM_W-1:0] param_value;
		logic [5:0]         osc_length;
		logic [7:0]         osc_byte;
		logic               last_item;
	} tesp_seq_t;

endpackage

`default_nettype wire

// File: hw/rtl/tesp_stream_if.sv
`default_nettype none

interface tesp_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/terminal_escape_sequence_parser.sv
// Terminal escape sequence parser.
// bytes: one terminal output byte per request (payload.byte_in, tesp_byte_t).
// seqs: finished sequences (tesp_seq_t), one request per CSI parameter or per
// buffered OSC byte, at least one per sequence, last_item set on the final one.
// Throughput: one byte per cycle while a sequence is being collected. On the
// terminating byte the parser stops taking bytes and drains the sequence from
// its parameter and OSC memories, one result per cycle while seqs.ready is
// high; bytes.ready stays low until the last result is drained. Each result is
// issued in state EMIT, registered in the read stage, then in the output
// register. The rate is set by the single read port of each memory.
// The current CSI parameter accumulates in a register and is stored on ';' or
// on the final byte, so memories only ever see entries written since the last
// ESC and need no clearing pass.
// Stall: when seqs.ready is low the output register and one read stage hold;
// results are never dropped. A new byte is taken once the last result has left
// the read stage.
// Reset: parser goes to ground, record and output valid are cleared.
`default_nettype none

module terminal_escape_sequence_parser #(
	parameter int MAX_PARAMS       = tesp_pkg::MAX_PARAMS_DEF,
	parameter int OSC_BUFFER_BYTES = tesp_pkg::OSC_BUFFER_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tesp_stream_if.sink        bytes,
	tesp_stream_if.source      seqs
);
	import tesp_pkg::*;

	localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
	localparam int PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int OLEN_W = $clog2(OSC_BUFFER_BYTES);

	logic [PARAM_W-1:0] param_mem [MAX_PARAMS];
	logic [7:0]         osc_mem [OSC_BUFFER_BYTES];

	tesp_state_t        state_q, state_d;
	tesp_kind_t         kind_q, kind_d;
	logic [7:0]         final_q, final_d;
	logic [7:0]         marker_q, marker_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [PARAM_W-1:0] cur_q, cur_d;
	logic [OLEN_W-1:0]  olen_q, olen_d;

	logic               pwr_en;
	logic [PIDX_W-1:0]  pwr_addr;
	logic               owr_en;

	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               issued_q, issued_d;
	logic               issue, move, is_last;
	logic [IDX_W-1:0]   n_items;

	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               last_s1;
	logic [PARAM_W-1:0] param_rd_s1;
	logic [7:0]         osc_rd_s1;

	logic               out_v_q;
	tesp_seq_t          out_q;

	logic               take;
	logic [7:0]         b;
	logic [19:0]        prod;

	assign b     = bytes.payload.byte_in;
	assign take  = bytes.valid && bytes.ready;
	assign prod  = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0}
		+ 20'(b - C_DIGIT_LO);
	assign bytes.ready = (state_q != ST_EMIT);

	assign move = v_s1 && (!out_v_q || seqs.ready);
	assign pwr_addr = PIDX_W'(count_q - CNT_W'(1));

	always_comb begin
		n_items = IDX_W'(1);
		if (kind_q == KIND_CSI && count_q > CNT_W'(1))
			n_items = IDX_W'(count_q);
		if (kind_q == KIND_OSC && olen_q > OLEN_W'(1))
			n_items = IDX_W'(olen_q);
	end

	assign is_last = (idx_q == n_items - IDX_W'(1));

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		final_d  = final_q;
		marker_d = marker_q;
		count_d  = count_q;
		cur_d    = cur_q;
		olen_d   = olen_q;
		pwr_en   = 1'b0;
		owr_en   = 1'b0;
		idx_d    = idx_q;
		issued_d = issued_q;
		issue    = 1'b0;
		case (state_q)
			ST_ESC: begin
				if (take) begin
					if (b == C_CSI) begin
						kind_d  = KIND_CSI;
						state_d = ST_CSI_ARG;
					end else if (b == C_OSC) begin
						kind_d  = KIND_OSC;
						state_d = ST_OSC;
					end else if (b == C_DCS) begin
						kind_d  = KIND_DCS;
						state_d = ST_DCS;
					end else if (b inside {[C_FINAL_LO:C_FINAL_HI]}) begin
						kind_d  = KIND_SIMPLE;
						final_d = b;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CSI_ARG: begin
				if (take) begin
					if (b == C_QMARK || b == C_GT) begin
						marker_d = b;
					end else if (b inside {[C_DIGIT_LO:C_DIGIT_HI]}) begin
						if (count_q == '0)
							count_d = CNT_W'(1);
						cur_d = (prod > 20'hFFFF) ? '1 : prod[PARAM_W-1:0];
					end else if (b == C_SEMI) begin
						if (count_q == '0) begin
							count_d = CNT_W'(1);
						end else if (count_q < CNT_W'(MAX_PARAMS)) begin
							pwr_en  = 1'b1;
							cur_d   = '0;
							count_d = count_q + CNT_W'(1);
						end
					end else if (b inside {[C_FINAL_LO:C_FINAL_HI]}) begin
						final_d = b;
						pwr_en  = (count_q != '0);
						state_d = ST_EMIT;
					end else if (b inside {[C_INTER_LO:C_INTER_HI]}) begin
						state_d = ST_CSI_MID;
					end
				end
			end
			ST_CSI_MID: begin
				if (take && (b inside {[C_FINAL_LO:C_FINAL_HI]})) begin
					final_d = b;
					pwr_en  = (count_q != '0);
					state_d = ST_EMIT;
				end
			end
			ST_OSC: begin
				if (take) begin
					if (b == C_BEL || b == C_ST || b == C_ESC) begin
						state_d = ST_EMIT;
					end else if (olen_q < OLEN_W'(OSC_BUFFER_BYTES - 1)) begin
						owr_en = 1'b1;
						olen_d = olen_q + OLEN_W'(1);
					end
				end
			end
			ST_DCS: begin
				if (take && (b == C_ST || b == C_ESC))
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				issue = !issued_q && (!v_s1 || move);
				if (issue) begin
					idx_d = idx_q + IDX_W'(1);
					if (is_last)
						issued_d = 1'b1;
				end
				if (move && last_s1) begin
					state_d  = ST_IDLE;
					idx_d    = '0;
					issued_d = 1'b0;
				end
			end
			default: begin
				if (take && b == C_ESC) begin
					kind_d   = KIND_SIMPLE;
					final_d  = '0;
					marker_d = '0;
					count_d  = '0;
					cur_d    = '0;
					olen_d   = '0;
					state_d  = ST_ESC;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= KIND_SIMPLE;
			final_q  <= '0;
			marker_q <= '0;
			count_q  <= '0;
			cur_q    <= '0;
			olen_q   <= '0;
			idx_q    <= '0;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			final_q  <= final_d;
			marker_q <= marker_d;
			count_q  <= count_d;
			cur_q    <= cur_d;
			olen_q   <= olen_d;
			idx_q    <= idx_d;
			issued_q <= issued_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pwr_en)
			param_mem[pwr_addr] <= cur_q;
		if (issue)
			param_rd_s1 <= param_mem[idx_q[PIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (owr_en)
			osc_mem[olen_q] <= b;
		if (issue)
			osc_rd_s1 <= osc_mem[idx_q[OLEN_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (seqs.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// hold the record fields with each result; the record may change once drained
	always_ff @(posedge clk) begin
		if (move) begin
			out_q.seq_kind     <= kind_q;
			out_q.final_code   <= final_q;
			out_q.private_mark <= marker_q;
			out_q.param_count  <= 5'(count_q);
			out_q.item_index   <= idx_s1;
			out_q.param_value  <= (kind_q == KIND_CSI && count_q != '0)
				? param_rd_s1 : '0;
			out_q.osc_length   <= 6'(olen_q);
			out_q.osc_byte     <= (kind_q == KIND_OSC && olen_q != '0)
				? osc_rd_s1 : '0;
			out_q.last_item    <= last_s1;
		end
	end

	assign seqs.valid   = out_v_q;
	assign seqs.payload = out_q;

endmodule

`default_nettype wire
